FILE: rtl/core/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication that must hold on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/dpht_pkg.sv
`default_nettype none

package dpht_pkg;

    // field widths fixed by the item format
    localparam int KEY_W     = 64;
    localparam int PAYLOAD_W = 60;

    // commands carried in the input tuser
    localparam logic [1:0] CMD_PROBE = 2'd0;
    localparam logic [1:0] CMD_STORE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // payload: [7:0] depth, [39:8] score, [41:40] flag, [42] move_present,
    // [48:43] source, [54:49] target, [57:55] promo, [58] passant, [59] castles
    localparam logic [PAYLOAD_W-1:0] PAYLOAD_DEFAULT = PAYLOAD_W'(8'hFF);

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
    } t_entry;

endpackage

`default_nettype wire

FILE: rtl/core/depth_preferred_hash_table_unit.sv
`default_nettype none

// Direct-mapped, depth-preferred transposition table with one entry per slot
// (slot = key mod ENTRIES). Each input item carries a command in tuser: probe,
// store or clear. Every item gets exactly one result item; hit and written
// come back in tuser, the stored fields of a hit in tdata. Items are handled
// one at a time. A probe or store passes through the slot index unit (the low
// key bits for a power of two, else byte-weight folding and a reciprocal
// reduction) and one slot memory read; a store that replaces the slot is
// written back as the result is registered, after which the input is ready
// again. The result step waits while an earlier result has not been taken.
// A clear walks the memory one slot per cycle and then gives its result.
// After reset the same clearing pass runs before the first item is accepted.
// A finished result waits in an output register, so the next item can be
// accepted before it is taken.
module depth_preferred_hash_table_unit
    import dpht_pkg::*;
#(
    parameter int ENTRIES = 65536
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // key, depth, score, bound_flag, with_move, move_source, move_target,
    // move_promo, move_passant, move_castles, zero fill
    input  wire logic [127:0] i_s_axis_tdata,
    // cmd
    input  wire logic [1:0]   i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // found_depth, found_score, found_flag, found_move_present, found_source,
    // found_target, found_promo, found_passant, found_castles, zero fill
    output logic [63:0]       o_m_axis_tdata,
    // hit, written
    output logic [1:0]        o_m_axis_tuser
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic [2:0] ST_WIPE  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_INDEX = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_RESP  = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [IDX_W-1:0]     r_wipe_cnt, n_wipe_cnt;
    logic                 r_wipe_reply, n_wipe_reply;
    logic [1:0]           r_cmd;
    logic [123:0]         r_item;
    logic [IDX_W-1:0]     r_index;
    logic                 r_out_valid, n_out_valid;
    logic [63:0]          r_out_data;
    logic [1:0]           r_out_user;

    logic                 accept;
    logic                 out_free;
    logic                 idx_start;
    logic                 idx_done;
    logic [IDX_W-1:0]     idx_index;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    t_entry               mem_wdata;
    logic                 mem_re;
    t_entry               mem_rdata;

    logic                 key_match;
    logic                 keep_old;
    logic                 resp_hit;
    logic                 resp_written;
    logic [PAYLOAD_W-1:0] new_payload;
    logic                 resp_fire;

    assign accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_out_valid || i_m_axis_tready;
    assign idx_start = accept
                    && (i_s_axis_tuser == CMD_PROBE || i_s_axis_tuser == CMD_STORE);
    assign resp_fire = (r_state == ST_RESP) && out_free;

    dpht_index_unit #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (idx_start),
        .i_key   (i_s_axis_tdata[63:0]),
        .o_done  (idx_done),
        .o_index (idx_index)
    );

    dpht_slot_mem #(
        .DEPTH  (ENTRIES),
        .ADDR_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (idx_index),
        .o_rdata (mem_rdata)
    );

    // slot compare and depth-preferred replacement
    assign key_match    = mem_rdata.key == r_item[63:0];
    assign keep_old     = key_match
                       && ($signed(mem_rdata.payload[7:0]) > $signed(r_item[71:64]));
    assign resp_hit     = (r_cmd == CMD_PROBE) && key_match;
    assign resp_written = (r_cmd == CMD_STORE) && !keep_old;

    // move fields only when a move comes with the store
    assign new_payload = {(r_item[106] ? r_item[123:107] : 17'd0), r_item[106:64]};

    // memory port control: clearing pass or store write-back
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_index;
        mem_wdata = '{key: r_item[63:0], payload: new_payload};
        if (r_state == ST_WIPE) begin
            mem_we    = 1'b1;
            mem_waddr = r_wipe_cnt;
            mem_wdata = '{key: '0, payload: PAYLOAD_DEFAULT};
        end else if (resp_fire && resp_written) begin
            mem_we = 1'b1;
        end
    end

    assign mem_re = (r_state == ST_INDEX) && idx_done;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_wipe_cnt   = r_wipe_cnt;
        n_wipe_reply = r_wipe_reply;
        unique case (r_state)
            ST_WIPE: begin
                n_wipe_cnt = r_wipe_cnt + 1'b1;
                if (r_wipe_cnt == LAST_IDX) begin
                    n_wipe_cnt = '0;
                    n_state    = r_wipe_reply ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    priority if (idx_start) begin
                        n_state = ST_INDEX;
                    end else if (i_s_axis_tuser == CMD_CLEAR) begin
                        n_state      = ST_WIPE;
                        n_wipe_cnt   = '0;
                        n_wipe_reply = 1'b1;
                    end else begin
                        n_state = ST_RESP;
                    end
                end
            end
            ST_INDEX: begin
                if (idx_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register handshake
    always_comb begin
        n_out_valid = r_out_valid;
        if (resp_fire) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_WIPE;
            r_wipe_cnt   <= '0;
            r_wipe_reply <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_wipe_cnt   <= n_wipe_cnt;
            r_wipe_reply <= n_wipe_reply;
            r_out_valid  <= n_out_valid;
        end
    end

    // item capture and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_s_axis_tuser;
            r_item <= i_s_axis_tdata[123:0];
        end
        if (mem_re) begin
            r_index <= idx_index;
        end
        if (resp_fire) begin
            r_out_user <= {resp_written, resp_hit};
            r_out_data <= resp_hit ? {4'd0, mem_rdata.payload} : 64'd0;
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

FILE: rtl/core/dpht_index_unit.sv
`default_nettype none

module dpht_index_unit
    import dpht_pkg::*;
#(
    parameter int ENTRIES = 65536,
    parameter int IDX_W   = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [KEY_W-1:0] i_key,
    output logic                  o_done,
    output logic [IDX_W-1:0]      o_index
);

    localparam bit IS_POW2 = (ENTRIES & (ENTRIES - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            // power of two table: slot is the low key bits
            localparam logic [IDX_W-1:0] MASK = IDX_W'(ENTRIES - 1);
            logic             r_done;
            logic [IDX_W-1:0] r_idx;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_idx <= i_key[IDX_W-1:0] & MASK;
                end
            end

            assign o_done  = r_done;
            assign o_index = r_idx;
        end else begin : g_reduce
            // key bytes weighted by 2^(8b) mod ENTRIES and summed, then a
            // reciprocal quotient estimate (low by at most two) and a final
            // compare and subtract, each step registered after the key is captured
            localparam int SUM_W = IDX_W + 11;
            localparam int XT_W  = 12;
            localparam int M_W   = 13;
            localparam int PR_W  = XT_W + M_W;
            localparam logic [63:0] NUM = 64'(ENTRIES);
            localparam logic [IDX_W-1:0] WGT [8] = '{
                IDX_W'(64'd1 % NUM),
                IDX_W'((64'd1 << 8) % NUM),
                IDX_W'((64'd1 << 16) % NUM),
                IDX_W'((64'd1 << 24) % NUM),
                IDX_W'((64'd1 << 32) % NUM),
                IDX_W'((64'd1 << 40) % NUM),
                IDX_W'((64'd1 << 48) % NUM),
                IDX_W'((64'd1 << 56) % NUM)
            };
            localparam logic [M_W-1:0]     RECIP = M_W'((64'd1 << (IDX_W + 12)) / NUM);
            localparam logic [SUM_W-1:0]   NUM_S = SUM_W'(ENTRIES);
            localparam logic [IDX_W+1:0]   ONE_N = (IDX_W + 2)'(ENTRIES);
            localparam logic [IDX_W+1:0]   TWO_N = (IDX_W + 2)'(2 * ENTRIES);

            logic [3:0]       r_stage;
            logic             r_done;
            logic [KEY_W-1:0] r_key;
            logic [SUM_W-1:0] r_sum, n_sum;
            logic [PR_W-1:0]  n_prod;
            logic [XT_W-1:0]  r_quot;
            logic [SUM_W-1:0] n_diff;
            logic [IDX_W+1:0] r_part;
            logic [IDX_W+1:0] n_sub;
            logic [IDX_W-1:0] r_rem, n_rem;

            // weighted byte sum, below 2^11 times ENTRIES
            always_comb begin
                n_sum = '0;
                for (int b = 0; b < 8; b++) begin
                    n_sum = n_sum + SUM_W'(r_key[8*b +: 8]) * SUM_W'(WGT[b]);
                end
            end

            // quotient estimate from the top bits of the sum
            assign n_prod = PR_W'(r_sum[SUM_W-1 -: XT_W]) * PR_W'(RECIP);

            // partial remainder, below three times ENTRIES
            assign n_diff = r_sum - SUM_W'(r_quot) * NUM_S;

            // final correction
            always_comb begin
                priority if (r_part >= TWO_N) begin
                    n_sub = r_part - TWO_N;
                end else if (r_part >= ONE_N) begin
                    n_sub = r_part - ONE_N;
                end else begin
                    n_sub = r_part;
                end
                n_rem = n_sub[IDX_W-1:0];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_stage <= '0;
                    r_done  <= 1'b0;
                end else begin
                    r_stage <= {r_stage[2:0], i_start};
                    r_done  <= r_stage[3];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_key <= i_key;
                end
                if (r_stage[0]) begin
                    r_sum <= n_sum;
                end
                if (r_stage[1]) begin
                    r_quot <= n_prod[PR_W-1 -: XT_W];
                end
                if (r_stage[2]) begin
                    r_part <= n_diff[IDX_W+1:0];
                end
                if (r_stage[3]) begin
                    r_rem <= n_rem;
                end
            end

            assign o_done  = r_done;
            assign o_index = r_rem;
        end
    endgenerate

endmodule

`default_nettype wire

FILE: rtl/core/dpht_slot_mem.sv
`default_nettype none

module dpht_slot_mem
    import dpht_pkg::*;
#(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire t_entry            i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output t_entry                 o_rdata
);

    t_entry mem [DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/dpht_checker.sv
`default_nettype none

`include "assert_macros.svh"

module dpht_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [63:0]  o_m_axis_tdata,
    input wire logic [1:0]   o_m_axis_tuser
);

    // a waiting result stays offered
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "result item dropped while stalled")

    // one item at a time: not ready right after an accept
    `ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "ready again right after an accepted item")

    // a probe hit and a store write never come together
    `ASSERT_CLK(a_hit_xor_written, i_clk, i_rst_n, o_m_axis_tvalid |-> !(o_m_axis_tuser[0] && o_m_axis_tuser[1]), "hit and written both set")

    // anything but a hit returns zero fields
    `ASSERT_CLK(a_miss_zero, i_clk, i_rst_n, (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == 64'd0), "non-hit result carries data")

endmodule

bind depth_preferred_hash_table_unit dpht_checker u_dpht_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire
